FILE: sv/vbob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbob_pkg
// Shared constants, request codes and controller/datapath interface types
// for the voxel brick occupancy builder.
// ----------------------------------------------------------------------------
package vbob_pkg;

  localparam int MAX_BRICKS = 4096;
  localparam int MAX_DIM    = 64;

  localparam int ADDR_W   = $clog2(MAX_BRICKS);     // brick store address
  localparam int POS_W    = $clog2(MAX_DIM);        // voxel position per axis
  localparam int SIZE_W   = 7;                      // size register width
  localparam int LPOS_W   = 2;                      // position inside a brick
  localparam int BPOS_W   = POS_W - LPOS_W;         // brick coordinate
  localparam int NB_W     = BPOS_W + 1;             // bricks along one axis
  localparam int NBXY_W   = 2 * BPOS_W + 1;         // bricks in one z layer
  localparam int IDX_W    = 3 * BPOS_W + 2;         // full brick index / count
  localparam int MASK_W   = 64;
  localparam int BIT_W    = 6;
  localparam int VALUE_W  = 8;
  localparam int REQ_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_DIM);

  // request codes
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic take;        // latch the incoming item
    logic prep;        // register the layer brick count
    logic eval;        // evaluate the item, issue the store read
    logic write_bit;   // write back the word with the new bit set
    logic clear_step;  // zero one store entry, advance the sweep
    logic load_out;    // load the result register
  } vbob_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             set_needed;
    logic             clear_last;
    logic             out_free;
  } vbob_status_t;

  // size register as the volume sees it: 0 acts as 1, above MAX_DIM clamps
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic logic [NB_W-1:0] bricks_along(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] e;
    logic [SIZE_W:0]   t;
    e = eff_size(s);
    t = {1'b0, e} + (SIZE_W + 1)'(3);
    return t[LPOS_W +: NB_W];
  endfunction

endpackage

FILE: sv/vbob_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbob_ctrl
// Sequencer: accepts one item at a time, steps the datapath through its
// evaluate / read-modify-write / respond phases and runs the store sweep.
// ----------------------------------------------------------------------------
module vbob_ctrl import vbob_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  vbob_status_t status,
  output vbob_cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (status.req == REQ_SAMPLE) begin
          state_next = status.set_needed ? ST_WRITE : ST_IDLE;
        end else if (status.req == REQ_READ) begin
          state_next = ST_RESP;
        end else if (status.req == REQ_CLEAR) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd.write_bit = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_RESP: begin
        // hold until the result register has room
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/vbob_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbob_datapath
// Size registers, raster position, brick index arithmetic, the brick store
// memory and the result register.
// ----------------------------------------------------------------------------
module vbob_datapath import vbob_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [VALUE_W-1:0]   voxel_value,
  input  logic [ADDR_W-1:0]    brick_addr,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [MASK_W-1:0]    occupancy_mask,
  output logic                 read_status,
  output logic                 model_complete,
  input  vbob_cmd_t            cmd,
  output vbob_status_t         status
);

  logic [SIZE_W-1:0]  size_x;
  logic [SIZE_W-1:0]  size_y;
  logic [SIZE_W-1:0]  size_z;

  logic [REQ_W-1:0]   req_q;
  logic [VALUE_W-1:0] value_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [NBXY_W-1:0]  nbxy_q;

  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [POS_W-1:0]   pos_z;
  logic               volume_done;

  logic [ADDR_W-1:0]  idx_q;
  logic [BIT_W-1:0]   bit_q;
  logic               addr_ok_q;
  logic [ADDR_W-1:0]  clr_cnt;

  logic [MASK_W-1:0]  brick_mem [MAX_BRICKS];
  logic [MASK_W-1:0]  rd_data;

  logic [SIZE_W-1:0]  sx;
  logic [SIZE_W-1:0]  sy;
  logic [SIZE_W-1:0]  sz;
  logic [NB_W-1:0]    nbx;
  logic [NB_W-1:0]    nby;
  logic [NB_W-1:0]    nbz;
  logic [NBXY_W-1:0]  prod_y;
  logic [IDX_W-1:0]   prod_z;
  logic [IDX_W-1:0]   idx_full;
  logic [IDX_W-1:0]   brick_count;
  logic               in_range;
  logic               addr_ok;
  logic [SIZE_W-1:0]  px_inc;
  logic [SIZE_W-1:0]  py_inc;
  logic [SIZE_W-1:0]  pz_inc;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [MASK_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  assign sx  = eff_size(size_x);
  assign sy  = eff_size(size_y);
  assign sz  = eff_size(size_z);
  assign nbx = bricks_along(size_x);
  assign nby = bricks_along(size_y);
  assign nbz = bricks_along(size_z);

  assign in_range = ({1'b0, pos_x} < sx) && ({1'b0, pos_y} < sy) &&
                    ({1'b0, pos_z} < sz);

  assign prod_y   = NBXY_W'(pos_y[POS_W-1:LPOS_W]) * NBXY_W'(nbx);
  assign prod_z   = IDX_W'(pos_z[POS_W-1:LPOS_W]) * IDX_W'(nbxy_q);
  assign idx_full = IDX_W'(pos_x[POS_W-1:LPOS_W]) + IDX_W'(prod_y) + prod_z;

  assign brick_count = IDX_W'(nbxy_q) * IDX_W'(nbz);
  assign addr_ok     = (IDX_W'(addr_q) < brick_count);

  assign px_inc = {1'b0, pos_x} + SIZE_W'(1);
  assign py_inc = {1'b0, pos_y} + SIZE_W'(1);
  assign pz_inc = {1'b0, pos_z} + SIZE_W'(1);

  assign status.req        = req_q;
  assign status.set_needed = (req_q == REQ_SAMPLE) && !volume_done && in_range &&
                             (value_q != '0) && (idx_full < IDX_W'(MAX_BRICKS));
  assign status.clear_last = (clr_cnt == ADDR_W'(MAX_BRICKS - 1));
  assign status.out_free   = !out_valid || !out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data;
        CFG_SIZE_Y: size_y <= cfg_data;
        CFG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture and derived values
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q   <= req_type;
      value_q <= voxel_value;
      addr_q  <= brick_addr;
    end
    if (cmd.prep) begin
      nbxy_q <= NBXY_W'(nbx) * NBXY_W'(nby);
    end
    if (cmd.eval) begin
      idx_q     <= idx_full[ADDR_W-1:0];
      bit_q     <= {pos_z[LPOS_W-1:0], pos_y[LPOS_W-1:0], pos_x[LPOS_W-1:0]};
      addr_ok_q <= addr_ok;
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      volume_done <= 1'b0;
    end else if (cmd.eval && req_q == REQ_CLEAR) begin
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
      volume_done <= 1'b0;
    end else if (cmd.eval && req_q == REQ_SAMPLE && !volume_done) begin
      if (!in_range) begin
        volume_done <= 1'b1;
      end else if (px_inc < sx) begin
        pos_x <= px_inc[POS_W-1:0];
      end else begin
        pos_x <= '0;
        if (py_inc < sy) begin
          pos_y <= py_inc[POS_W-1:0];
        end else begin
          pos_y <= '0;
          if (pz_inc < sz) begin
            pos_z <= pz_inc[POS_W-1:0];
          end else begin
            pos_z       <= '0;
            volume_done <= 1'b1;
          end
        end
      end
    end
  end

  // clearing sweep counter; wraps back to zero at the end of each sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // brick store: one write port, one registered read port
  assign mem_we    = cmd.clear_step || cmd.write_bit;
  assign mem_waddr = cmd.clear_step ? clr_cnt : idx_q;
  assign mem_wdata = cmd.clear_step ? '0 : (rd_data | (MASK_W'(1) << bit_q));
  assign mem_raddr = (req_q == REQ_READ) ? addr_q : idx_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      brick_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.eval) begin
      rd_data <= brick_mem[mem_raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      occupancy_mask <= addr_ok_q ? rd_data : '0;
      read_status    <= !addr_ok_q;
      model_complete <= volume_done;
    end
  end

endmodule

FILE: sv/voxel_brick_occupancy_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_brick_occupancy_builder_core
// Builds 4x4x4 brick occupancy words from a raster voxel stream and answers
// brick read requests.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  req_type, voxel_value, brick_addr
//   out      out_valid / out_stall occupancy_mask, read_status, model_complete
//   cfg      cfg_we               cfg_index, cfg_data (size_x, size_y, size_z)
//
// One item at a time. A sample steps through prep and evaluate, plus a write
// state when it sets a bit (the registered store read comes back before the
// updated word is written). A read steps through prep, evaluate and respond.
// A clear steps through prep and evaluate, then a sweep zeroes all 4096 store
// entries. After reset the same sweep runs before the first item is taken.
// The result register lets the next item in while a read result is stalled;
// a second read waits for it to drain.
// ----------------------------------------------------------------------------
module voxel_brick_occupancy_builder_core import vbob_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [REQ_W-1:0]     req_type,
  input  logic [VALUE_W-1:0]   voxel_value,
  input  logic [ADDR_W-1:0]    brick_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [MASK_W-1:0]    occupancy_mask,
  output logic                 read_status,
  output logic                 model_complete,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  vbob_cmd_t    cmd;
  vbob_status_t status;

  vbob_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vbob_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .voxel_value    (voxel_value),
    .brick_addr     (brick_addr),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .occupancy_mask (occupancy_mask),
    .read_status    (read_status),
    .model_complete (model_complete),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

FILE: bench/tb_voxel_brick_occupancy_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_brick_occupancy_builder_core
// Streams voxel samples, brick reads and clears into the occupancy builder.
// A shadow copy of the brick store and raster position predicts each read
// reply. The checker compares every reply, field by field, in order. Phases
// vary the volume size and the idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_voxel_brick_occupancy_builder_core import vbob_pkg::*; ();

  localparam int CYCLE_LIMIT = 1500000;
  localparam int ITEM_TARGET = 1850;
  localparam int SWEEP_WAIT  = 4200;
  localparam int SETTLE_WAIT = 8;
  localparam int HOLD_LEN    = 400;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic              status;
    logic              complete;
  } brick_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [REQ_W-1:0]     req_type = REQ_SAMPLE;
  logic [VALUE_W-1:0]   voxel_value = '0;
  logic [ADDR_W-1:0]    brick_addr = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [MASK_W-1:0]    occupancy_mask;
  logic                 read_status;
  logic                 model_complete;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SIZE_X;
  logic [SIZE_W-1:0]    cfg_data = '0;

  // shadow of the block state
  logic [SIZE_W-1:0] size_shadow [0:2];
  logic [MASK_W-1:0] occupancy_shadow [MAX_BRICKS];
  int unsigned       cur_x, cur_y, cur_z;
  bit                volume_full;
  bit                sweep_pending = 1'b1;
  brick_reply_t      expected_replies[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent  = 0;
  int reads_sent  = 0;
  int clears_sent = 0;
  int size_writes = 0;
  int replies_checked = 0;

  voxel_brick_occupancy_builder_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .voxel_value    (voxel_value),
    .brick_addr     (brick_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .occupancy_mask (occupancy_mask),
    .read_status    (read_status),
    .model_complete (model_complete),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
               expected_replies.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIZE_W'(MAX_DIM)) return MAX_DIM;
    return s;
  endfunction

  function automatic int unsigned bricks_on_axis(input logic [SIZE_W-1:0] s);
    return (clamp_dim(s) + 3) / 4;
  endfunction

  function automatic int unsigned brick_total();
    return bricks_on_axis(size_shadow[CFG_SIZE_X]) * bricks_on_axis(size_shadow[CFG_SIZE_Y])
           * bricks_on_axis(size_shadow[CFG_SIZE_Z]);
  endfunction

  task automatic report_mismatch(input string what, input logic [MASK_W-1:0] got,
                                 input logic [MASK_W-1:0] want);
    $display("MISMATCH %s at %0t: got %h expected %h", what, $time, got, want);
    error_count++;
  endtask

  // Update the shadow state for one accepted item; queue the reply of a read.
  task automatic predict_item(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] value,
                              input logic [ADDR_W-1:0] addr);
    int unsigned  sx, sy, sz, nbx, nby, idx, bitpos;
    brick_reply_t reply;
    sx  = clamp_dim(size_shadow[CFG_SIZE_X]);
    sy  = clamp_dim(size_shadow[CFG_SIZE_Y]);
    sz  = clamp_dim(size_shadow[CFG_SIZE_Z]);
    nbx = bricks_on_axis(size_shadow[CFG_SIZE_X]);
    nby = bricks_on_axis(size_shadow[CFG_SIZE_Y]);
    case (req)
      REQ_SAMPLE: begin
        if (!volume_full) begin
          if (cur_x >= sx || cur_y >= sy || cur_z >= sz) begin
            // position outside a shrunken volume: drop and close the volume
            volume_full = 1'b1;
          end else begin
            idx = (cur_x >> 2) + (cur_y >> 2) * nbx + (cur_z >> 2) * nbx * nby;
            bitpos = (cur_x & 3) + ((cur_y & 3) << 2) + ((cur_z & 3) << 4);
            if (value != '0 && idx < MAX_BRICKS) begin
              occupancy_shadow[idx] |= MASK_W'(1) << bitpos;
            end
            cur_x++;
            if (cur_x >= sx) begin
              cur_x = 0;
              cur_y++;
              if (cur_y >= sy) begin
                cur_y = 0;
                cur_z++;
                if (cur_z >= sz) begin
                  cur_z = 0;
                  volume_full = 1'b1;
                end
              end
            end
          end
        end
      end
      REQ_READ: begin
        if (addr < brick_total() && addr < MAX_BRICKS) begin
          reply.mask   = occupancy_shadow[addr];
          reply.status = 1'b0;
        end else begin
          reply.mask   = '0;
          reply.status = 1'b1;
        end
        reply.complete = volume_full;
        expected_replies.push_back(reply);
        sweep_pending = 1'b0;
        reads_sent++;
      end
      REQ_CLEAR: begin
        foreach (occupancy_shadow[i]) occupancy_shadow[i] = '0;
        cur_x = 0;
        cur_y = 0;
        cur_z = 0;
        volume_full = 1'b0;
        sweep_pending = 1'b1;
        clears_sent++;
      end
      default: ;
    endcase
  endtask

  // Offer one item, hold it until accepted, then predict it.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] value,
                           input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    voxel_value <= value;
    brick_addr  <= addr;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_item(req, value, addr);
    if (req != REQ_UNKNOWN) items_sent++;
  endtask

  // Drop valid, wait for every reply, then let any sample or sweep finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (sweep_pending ? SWEEP_WAIT : SETTLE_WAIT) @(posedge clk);
    sweep_pending = 1'b0;
  endtask

  task automatic write_sizes(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                             input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] vals [0:2];
    vals[0] = sx;
    vals[1] = sy;
    vals[2] = sz;
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      size_shadow[i] = vals[i];
      size_writes++;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin sender_idle_pct = 71; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
      default:       begin sender_idle_pct = 9;  recv_stall_pct = 9;  end
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return SIZE_W'($urandom_range(1, 8));
    if (r < 75) return SIZE_W'($urandom_range(9, 64));
    if (r < 85) return SIZE_W'(MAX_DIM);
    if (r < 90) return '0;
    return SIZE_W'($urandom_range(65, 127));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned r, total, a;
    r = $urandom_range(99);
    total = brick_total();
    if (r < 70) begin
      a = $urandom_range(total - 1);
    end else if (r < 85) begin
      a = total + $urandom_range(3);
      if (a > MAX_BRICKS - 1) a = MAX_BRICKS - 1;
    end else begin
      a = $urandom_range(MAX_BRICKS - 1);
    end
    return ADDR_W'(a);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(1) == 0) return '0;
    return VALUE_W'($urandom_range(1, 255));
  endfunction

  // receiver: random stalls, or a long hold when a test asks for one
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked != holds_done) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_reply
    brick_reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with none expected", occupancy_mask, '0);
      end else begin
        want = expected_replies.pop_front();
        if (occupancy_mask !== want.mask)
          report_mismatch("occupancy_mask", occupancy_mask, want.mask);
        if (read_status !== want.status)
          report_mismatch("read_status", MASK_W'(read_status), MASK_W'(want.status));
        if (model_complete !== want.complete)
          report_mismatch("model_complete", MASK_W'(model_complete), MASK_W'(want.complete));
        replies_checked++;
      end
    end
  end

  // default sizes, empty store, unknown request ignored
  task automatic test_reset_state();
    send_item(REQ_READ, '0, '0);
    send_item(REQ_READ, 8'hff, 12'hfff);
    send_item(REQ_UNKNOWN, 8'h5a, 12'h800);
    send_item(REQ_READ, '0, 12'h800);
  endtask

  // one-voxel volume, samples past the end, zero size acting as one
  task automatic test_single_voxel();
    settle();
    write_sizes(7'd1, 7'd1, 7'd1);
    send_item(REQ_CLEAR, '0, '0);
    send_item(REQ_SAMPLE, 8'hff, '0);
    send_item(REQ_SAMPLE, 8'h09, '0);
    send_item(REQ_READ, '0, '0);
    send_item(REQ_READ, '0, 12'd1);
    settle();
    write_sizes('0, '0, '0);
    send_item(REQ_READ, '0, '0);
    send_item(REQ_READ, '0, 12'hfff);
  endtask

  // partial brick on every axis, empty samples leave their bit clear
  task automatic test_small_brick();
    settle();
    write_sizes(7'd2, 7'd1, 7'd2);
    send_item(REQ_CLEAR, '0, '0);
    send_item(REQ_SAMPLE, 8'h01, '0);
    send_item(REQ_SAMPLE, 8'h00, '0);
    send_item(REQ_SAMPLE, 8'h80, '0);
    send_item(REQ_SAMPLE, 8'hff, '0);
    send_item(REQ_SAMPLE, 8'h42, '0);
    send_item(REQ_READ, '0, '0);
  endtask

  // shrink x under the current position, then clamp sizes above the limit
  task automatic test_size_change();
    settle();
    write_sizes(7'd4, 7'd4, 7'd4);
    send_item(REQ_CLEAR, '0, '0);
    repeat (5) send_item(REQ_SAMPLE, 8'h80, '0);
    settle();
    write_sizes(7'd1, 7'd4, 7'd4);
    send_item(REQ_SAMPLE, 8'h01, '0);
    send_item(REQ_READ, '0, '0);
    settle();
    write_sizes(7'd127, 7'd65, 7'd64);
    send_item(REQ_READ, '0, 12'hfff);
  endtask

  // hold the result channel while reads keep coming, so the input backs up
  task automatic test_stall_pressure();
    settle();
    set_idle_mode(IDLE_NONE);
    write_sizes(7'd8, 7'd8, 7'd8);
    send_item(REQ_CLEAR, '0, '0);
    holds_asked++;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_item(REQ_SAMPLE, pick_value(), '0);
      else send_item(REQ_READ, '0, pick_addr());
    end
    settle();
  endtask

  // whole volumes with random content, with reads, noise and broken streams
  task automatic test_random_traffic();
    int unsigned phase, vol, stream, r;
    logic [SIZE_W-1:0] sx, sy, sz;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      set_idle_mode(idle_mode_t'(phase % 4));
      sx = pick_size();
      sy = pick_size();
      sz = pick_size();
      write_sizes(sx, sy, sz);
      if ($urandom_range(9) != 0) send_item(REQ_CLEAR, pick_value(), pick_addr());
      vol = clamp_dim(sx) * clamp_dim(sy) * clamp_dim(sz);
      stream = (vol <= 250) ? vol + $urandom_range(3) : $urandom_range(40, 250);
      for (int i = 0; i < stream; i++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          send_item(REQ_READ, pick_value(), pick_addr());
        end else if (r < 10) begin
          send_item(REQ_UNKNOWN, pick_value(), pick_addr());
        end else if (r < 11) begin
          settle();
          sx = SIZE_W'($urandom_range(1, clamp_dim(sx)));
          write_sizes(sx, sy, sz);
          send_item(REQ_SAMPLE, pick_value(), pick_addr());
        end else begin
          send_item(REQ_SAMPLE, pick_value(), pick_addr());
        end
      end
      repeat ($urandom_range(6, 20)) send_item(REQ_READ, pick_value(), pick_addr());
      phase++;
    end
  endtask

  initial begin
    foreach (size_shadow[i]) size_shadow[i] = SIZE_W'(MAX_DIM);
    foreach (occupancy_shadow[i]) occupancy_shadow[i] = '0;
    cur_x = 0;
    cur_y = 0;
    cur_z = 0;
    volume_full = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_single_voxel();
    test_small_brick();
    test_size_change();
    test_stall_pressure();
    test_random_traffic();
    settle();
    $display("Sent %0d items: %0d reads, %0d clears, %0d size register writes",
             items_sent, reads_sent, clears_sent, size_writes);
    $display("Checked %0d brick replies in %0d cycles", replies_checked, cycle_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
